// ===== hdl/gpg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gpg_pkg;

  // grid geometry and sample width
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 1024;
  localparam int POT_W     = 24;
  localparam int MIN_ROWS  = 3;
  localparam int MIN_COLS  = 2;

  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);

  // result fields
  localparam int IDX_W     = 10;
  localparam int FLD_W     = 32;

  // configuration port
  localparam int CFG_DIM_W  = 11;
  localparam int INV_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SPACING = 2'd2;

  localparam logic [INV_W-1:0] INV_SPACING_RST = 16'd256;

  // arithmetic widths: difference, product, fractional bits of the spacing
  localparam int FRAC_W   = 8;
  localparam int DIFF_W   = POT_W + 1;
  localparam int PROD_MIN = DIFF_W + INV_W + 1;
  localparam int PROD_W   = (PROD_MIN > FLD_W + FRAC_W + 1) ? PROD_MIN : FLD_W + FRAC_W + 1;
  localparam int QUO_W    = PROD_W - FRAC_W;

  // command queue between front and back
  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [POT_W-1:0] drift_potential;
    logic signed [POT_W-1:0] weight_potential;
  } gpg_in_t;

  typedef struct packed {
    logic        [IDX_W-1:0] col_index;
    logic        [IDX_W-1:0] row_index;
    logic signed [FLD_W-1:0] drift_field_x;
    logic signed [FLD_W-1:0] drift_field_y;
    logic signed [FLD_W-1:0] weight_field_x;
    logic signed [FLD_W-1:0] weight_field_y;
    logic                    last_of_run;
  } gpg_out_t;

  // what the back does with a command
  typedef enum logic [1:0] {
    KIND_MID  = 2'd0,  // compute and emit this row
    KIND_ROW1 = 2'd1,  // compute, emit row 1, then a copy for row 0
    KIND_LAST = 2'd2   // emit the held field for the last row
  } gpg_kind_t;

  typedef struct packed {
    gpg_kind_t               kind;
    logic        [COL_W-1:0] col;
    logic        [ROW_W-1:0] row;
    logic signed [POT_W-1:0] cur_drift;
    logic signed [POT_W-1:0] cur_weight;
    logic signed [POT_W-1:0] row_drift;
    logic signed [POT_W-1:0] row_weight;
    logic signed [POT_W-1:0] col_drift;
    logic signed [POT_W-1:0] col_weight;
  } gpg_cmd_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] num_columns;
    logic [CFG_DIM_W-1:0] num_rows;
    logic [INV_W-1:0]     inv_spacing;
  } gpg_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/gpg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpg_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read-first: a read and write to one address return the old word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/gpg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpg_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire gpg_pkg::gpg_cfg_t     cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire gpg_pkg::gpg_in_t      in_data,
  input  wire logic [gpg_pkg::QCNT_W-1:0] q_count,
  output logic                       push_valid,
  output gpg_pkg::gpg_cmd_t          push_cmd
);
  import gpg_pkg::*;

  logic [ROW_W-1:0] row_r, row_nxt, rows_m1, r;
  logic [COL_W-1:0] col_r, col_nxt, cols_m1, c;
  logic             last_row, last_col, accept;
  logic signed [POT_W-1:0] prev_drift_r, prev_weight_r;
  logic             a_valid_r;
  gpg_cmd_t         a_cmd_r, cmd;
  logic [2*POT_W-1:0] ram_rd;

  // clamp the grid extents to the supported range
  always_comb begin
    if (cfg.num_rows < CFG_DIM_W'(MIN_ROWS)) begin
      rows_m1 = ROW_W'(MIN_ROWS - 1);
    end else if (int'(cfg.num_rows) > MAX_ROWS) begin
      rows_m1 = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_m1 = ROW_W'(cfg.num_rows - CFG_DIM_W'(1));
    end
    if (cfg.num_columns < CFG_DIM_W'(MIN_COLS)) begin
      cols_m1 = COL_W'(MIN_COLS - 1);
    end else if (int'(cfg.num_columns) > MAX_COLS) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(cfg.num_columns - CFG_DIM_W'(1));
    end
  end

  assign last_row = (row_r >= rows_m1);
  assign last_col = (col_r >= cols_m1);
  assign r        = last_row ? rows_m1 : row_r;
  assign c        = last_col ? cols_m1 : col_r;

  assign in_ready = ({1'b0, q_count} + (QCNT_W+1)'(a_valid_r)) < (QCNT_W+1)'(Q_DEPTH);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = a_cmd_r;
    cmd.kind       = last_row ? KIND_LAST : ((r == ROW_W'(1)) ? KIND_ROW1 : KIND_MID);
    cmd.col        = c;
    cmd.row        = r;
    cmd.cur_drift  = in_data.drift_potential;
    cmd.cur_weight = in_data.weight_potential;
    cmd.row_drift  = prev_drift_r;
    cmd.row_weight = prev_weight_r;
  end

  always_comb begin
    if (last_row) begin
      row_nxt = '0;
      col_nxt = last_col ? '0 : col_r + COL_W'(1);
    end else begin
      row_nxt = r + ROW_W'(1);
      col_nxt = c;
    end
  end

  gpg_ram #(
    .WIDTH (2*POT_W),
    .DEPTH (MAX_ROWS)
  ) u_col_buf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (r),
    .wr_data ({in_data.drift_potential, in_data.weight_potential}),
    .rd_en   (accept),
    .rd_addr (r),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r         <= '0;
      col_r         <= '0;
      prev_drift_r  <= '0;
      prev_weight_r <= '0;
      a_valid_r     <= 1'b0;
    end else begin
      a_valid_r <= accept && (c != '0) && (r != '0);
      if (accept) begin
        row_r         <= row_nxt;
        col_r         <= col_nxt;
        prev_drift_r  <= in_data.drift_potential;
        prev_weight_r <= in_data.weight_potential;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_cmd_r <= cmd;
    end
  end

  // merge the previous column's sample as it leaves the buffer
  always_comb begin
    push_cmd            = a_cmd_r;
    push_cmd.col_drift  = ram_rd[2*POT_W-1:POT_W];
    push_cmd.col_weight = ram_rd[POT_W-1:0];
  end

  assign push_valid = a_valid_r;

endmodule

`default_nettype wire

// ===== hdl/gpg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpg_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push_valid,
  input  wire gpg_pkg::gpg_cmd_t          push_cmd,
  output logic                            pop_valid,
  input  wire logic                       pop,
  output gpg_pkg::gpg_cmd_t               pop_cmd,
  output logic [gpg_pkg::QCNT_W-1:0]      count
);
  import gpg_pkg::*;

  gpg_cmd_t            slot_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push_valid && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/gpg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gpg_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [gpg_pkg::INV_W-1:0] inv_spacing,
  input  wire logic                   q_valid,
  input  wire gpg_pkg::gpg_cmd_t      q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output gpg_pkg::gpg_out_t           out_data
);
  import gpg_pkg::*;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [FLD_W-1:0]  fld_t;

  function automatic fld_t sat_shift(input prod_t p);
    logic signed [QUO_W-1:0] q;
    logic [QUO_W-FLD_W:0]    top;
    begin
      q   = p[PROD_W-1:FRAC_W];
      top = q[QUO_W-1:FLD_W-1];
      if ((&top) || !(|top)) begin
        sat_shift = q[FLD_W-1:0];
      end else if (q[QUO_W-1]) begin
        sat_shift = {1'b1, {(FLD_W-1){1'b0}}};
      end else begin
        sat_shift = {1'b0, {(FLD_W-1){1'b1}}};
      end
    end
  endfunction

  // stage 1: differences
  logic       p1_valid_r;
  gpg_kind_t  p1_kind_r;
  logic [COL_W-1:0] p1_col_r;
  logic [ROW_W-1:0] p1_row_r;
  diff_t      p1_dx_r, p1_dy_r, p1_wx_r, p1_wy_r;
  // stage 2: products
  logic       p2_valid_r;
  gpg_kind_t  p2_kind_r;
  logic [COL_W-1:0] p2_col_r;
  logic [ROW_W-1:0] p2_row_r;
  prod_t      p2_dx_r, p2_dy_r, p2_wx_r, p2_wy_r;
  prod_t      scale;
  // output stage
  logic       out_valid_r, pend_r;
  gpg_out_t   out_r, out_nxt;
  fld_t       held_r [4];
  fld_t       fld    [4];
  logic       ld_out, p2_en, p1_en;

  assign ld_out = p2_valid_r && (!out_valid_r || (out_ready && !pend_r));
  assign p2_en  = !p2_valid_r || ld_out;
  assign p1_en  = !p1_valid_r || p2_en;
  assign q_pop  = q_valid && p1_en;
  assign scale  = PROD_W'($signed({1'b0, inv_spacing}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (p1_en) begin
        p1_valid_r <= q_valid;
      end
      if (p2_en) begin
        p2_valid_r <= p1_valid_r;
      end
      if (out_valid_r && out_ready && pend_r) begin
        pend_r <= 1'b0;
      end else if (ld_out) begin
        out_valid_r <= 1'b1;
        pend_r      <= (p2_kind_r == KIND_ROW1);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p1_kind_r <= q_cmd.kind;
      p1_col_r  <= q_cmd.col;
      p1_row_r  <= q_cmd.row;
      p1_dx_r   <= DIFF_W'(q_cmd.col_drift)  - DIFF_W'(q_cmd.cur_drift);
      p1_dy_r   <= DIFF_W'(q_cmd.row_drift)  - DIFF_W'(q_cmd.cur_drift);
      p1_wx_r   <= DIFF_W'(q_cmd.col_weight) - DIFF_W'(q_cmd.cur_weight);
      p1_wy_r   <= DIFF_W'(q_cmd.row_weight) - DIFF_W'(q_cmd.cur_weight);
    end
    if (p2_en && p1_valid_r) begin
      p2_kind_r <= p1_kind_r;
      p2_col_r  <= p1_col_r;
      p2_row_r  <= p1_row_r;
      p2_dx_r   <= PROD_W'(p1_dx_r) * scale;
      p2_dy_r   <= PROD_W'(p1_dy_r) * scale;
      p2_wx_r   <= PROD_W'(p1_wx_r) * scale;
      p2_wy_r   <= PROD_W'(p1_wy_r) * scale;
    end
  end

  // last row reuses the most recently computed field
  always_comb begin
    case (p2_kind_r)
      KIND_LAST: begin
        fld[0] = held_r[0];
        fld[1] = held_r[1];
        fld[2] = held_r[2];
        fld[3] = held_r[3];
      end
      default: begin
        fld[0] = sat_shift(p2_dx_r);
        fld[1] = sat_shift(p2_dy_r);
        fld[2] = sat_shift(p2_wx_r);
        fld[3] = sat_shift(p2_wy_r);
      end
    endcase
    out_nxt.col_index      = IDX_W'(p2_col_r);
    out_nxt.row_index      = IDX_W'(p2_row_r);
    out_nxt.drift_field_x  = fld[0];
    out_nxt.drift_field_y  = fld[1];
    out_nxt.weight_field_x = fld[2];
    out_nxt.weight_field_y = fld[3];
    out_nxt.last_of_run    = (p2_kind_r != KIND_ROW1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r[0] <= '0;
      held_r[1] <= '0;
      held_r[2] <= '0;
      held_r[3] <= '0;
    end else if (ld_out && (p2_kind_r != KIND_LAST)) begin
      held_r[0] <= fld[0];
      held_r[1] <= fld[1];
      held_r[2] <= fld[2];
      held_r[3] <= fld[3];
    end
  end

  // second beat of a row-1 item: same field, row 0
  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready && pend_r) begin
      out_r.row_index   <= '0;
      out_r.last_of_run <= 1'b1;
    end else if (ld_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== hdl/grid_potential_gradient_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path: front command register, queue, difference and product stages, output
//   register; a row-1 item gives its row-0 copy on the following beat.
// Throughput: one item per cycle unless stalled; the output carries one beat per
//   cycle, so a row-1 item's copy stalls it. Row 0 and column 0 items give no beat.
// Reset: synchronous, active low; clears counters, handshake state and held field
//   and restores register defaults. The column buffer is not cleared.

module grid_potential_gradient_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire gpg_pkg::gpg_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output gpg_pkg::gpg_out_t                      out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [gpg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gpg_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import gpg_pkg::*;

  gpg_cfg_t           cfg_r;
  logic               push_valid, q_valid, q_pop;
  gpg_cmd_t           push_cmd, q_cmd;
  logic [QCNT_W-1:0]  q_count;

  // Register writes are always taken; writes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_columns <= CFG_DIM_W'(MAX_COLS);
      cfg_r.num_rows    <= CFG_DIM_W'(MAX_ROWS);
      cfg_r.inv_spacing <= INV_SPACING_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_COLUMNS: cfg_r.num_columns <= cfg_data[CFG_DIM_W-1:0];
        CFG_NUM_ROWS:    cfg_r.num_rows    <= cfg_data[CFG_DIM_W-1:0];
        CFG_INV_SPACING: cfg_r.inv_spacing <= cfg_data[INV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: track the grid position, read and refill the column buffer, and
  // classify each beat. Only beats that give results go to the queue.
  gpg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_cmd   (push_cmd)
  );

  // Queue: decouple the front from output stalls.
  gpg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd),
    .count      (q_count)
  );

  // Back: difference, scale, saturate, and drive the result beats.
  gpg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .inv_spacing (cfg_r.inv_spacing),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

`ifndef SYNTHESIS
  // The front reserves queue space before accepting, so the queue never overfills.
  assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(Q_DEPTH))
    else $error("command queue overflow");

  // A row-0 beat is always the closing copy of a row-1 item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.row_index == '0)) |-> out_data.last_of_run)
    else $error("row 0 beat not marked last");

  // A row-1 beat is always followed by its row-0 copy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && (out_data.row_index == IDX_W'(1))) |=>
      (out_valid && (out_data.row_index == '0)))
    else $error("row 1 beat without row 0 copy");
`endif

endmodule

`default_nettype wire
